// ----- src/tsp_pkg.sv -----
// tsp_pkg: shared types, sizes and the note step ROM of the tracker sample player.
// Used by tsp_divider, tracker_sample_player, tsp_checker, tsp_scoreboard and tb_top.
`default_nettype none
package tsp_pkg;

   localparam int PATTERN_COUNT    = 16;
   localparam int ROWS_PER_PATTERN = 64;
   localparam int ARRANGE_DEPTH    = 64;
   localparam int INSTRUMENT_COUNT = 15;
   localparam int SAMPLE_DEPTH     = 8192;
   localparam int CHANNELS         = 4;

   localparam int PAT_W    = 4;
   localparam int ROW_W    = 6;
   localparam int CH_W     = 2;
   localparam int NOTE_W   = 7;
   localparam int INST_W   = 4;
   localparam int SLOT_W   = 6;
   localparam int ADDR_W   = 13;
   localparam int SAMP_W   = 16;
   localparam int LEN_W    = 14;
   localparam int CELL_W   = NOTE_W + INST_W;
   localparam int CNT_W    = 32;
   localparam int STEP_W   = 24;
   localparam int DIV_W    = 24;
   localparam int SPC_W    = 16;
   localparam int ALEN_W   = 7;
   localparam int PROD_W   = CNT_W + STEP_W;
   localparam int HALF_W   = CNT_W / 2;
   localparam int PART_W   = HALF_W + STEP_W;
   localparam int POS_BITS = ADDR_W;
   localparam int ITER_W   = $clog2(POS_BITS + 1);
   localparam int SUM_W    = 18;
   localparam int ACC_W    = 20;
   localparam int CELL_TOTAL   = PATTERN_COUNT * ROWS_PER_PATTERN * CHANNELS;
   localparam int SAMPLE_TOTAL = INSTRUMENT_COUNT * SAMPLE_DEPTH;
   localparam int CELL_AW      = PAT_W + ROW_W + CH_W;
   localparam int SAMP_AW      = INST_W + ADDR_W;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 24;

   localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(131071);
   localparam logic signed [ACC_W-1:0] SUM_MIN = -ACC_W'(131072);

   typedef enum logic [2:0] {
      MODE_TICK   = 3'd0,
      MODE_PLAY   = 3'd1,
      MODE_STOP   = 3'd2,
      MODE_CELL   = 3'd3,
      MODE_ARR    = 3'd4,
      MODE_SAMPLE = 3'd5,
      MODE_LENGTH = 3'd6
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLES_PER_CELL = 2'd0,
      CSR_PITCH_DIVISOR    = 2'd1,
      CSR_ARRANGE_LENGTH   = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ARR, ST_CELL, ST_DECIDE, ST_MUL_LO, ST_MUL_HI, ST_PROD,
      ST_RANGE, ST_DIVIDE, ST_SREAD, ST_ACCUM, ST_TIMING, ST_FINISH
   } state_type;

   typedef logic [STEP_W-1:0] step_table_type [128];

   // note step: 2^20-scaled octave mantissa shifted down per octave, zero below note 12
   function automatic step_table_type build_steps();
      int unsigned base [12];
      step_table_type t;
      int oct;
      base = '{8572947, 9082720, 9622807, 10195009, 10801236, 11443511,
               12123977, 12844906, 13608704, 14417920, 15275254, 16183568};
      for (int n = 0; n < 128; n++) begin
         if (n < 12) begin
            t[n] = '0;
         end else begin
            oct  = n / 12;
            t[n] = STEP_W'(base[n % 12] >> (10 - oct));
         end
      end
      return t;
   endfunction

   localparam step_table_type NOTE_STEP = build_steps();

endpackage
`default_nettype wire

// ----- src/tsp_divider.sv -----
// tsp_divider: restoring divider, one quotient bit per cycle, POS_BITS bits.
// Caller guarantees the upper dividend part is below the divisor. Uses tsp_pkg.
`default_nettype none
module tsp_divider import tsp_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DIV_W-1:0]    num_hi,
   input  wire logic [POS_BITS-1:0] num_lo,
   input  wire logic [DIV_W-1:0]    divisor,
   output logic                     done,
   output logic [POS_BITS-1:0]      quotient
);

   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [POS_BITS-1:0] low_ff, low_in;
   logic [POS_BITS-1:0] q_ff, q_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DIV_W:0]      trial;
   logic                fits;

   always_comb begin
      trial   = {rem_ff, low_ff[POS_BITS-1]};
      fits    = trial >= {1'b0, divisor};
      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num_hi;
         low_in  = num_lo;
         iter_in = ITER_W'(POS_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
         low_in  = {low_ff[POS_BITS-2:0], 1'b0};
         q_in    = {q_ff[POS_BITS-2:0], fits};
         iter_in = iter_ff - 1'b1;
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      iter_ff <= iter_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

// ----- src/tracker_sample_player.sv -----
// tracker_sample_player: four-channel tracker playback around pattern, arrangement
// and sample memories. Uses tsp_pkg and tsp_divider.
// Load items (play, stop, writes) are taken in the idle state. A tick runs, per active
// channel, a two-part multiply, a divide for the 13-bit quotient and a sample read,
// and can stall on the result; the channel loop sets its length. One item at a time.
// Synchronous reset clears control state; pattern, arrangement and sample memories
// hold whatever was written; instrument lengths reset to SAMPLE_DEPTH.
`default_nettype none
module tracker_sample_player import tsp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [2:0]              req_mode,
   input  wire logic [PAT_W-1:0]        req_pattern_index,
   input  wire logic [CH_W-1:0]         req_channel,
   input  wire logic [ROW_W-1:0]        req_row,
   input  wire logic [NOTE_W-1:0]       req_note_number,
   input  wire logic [INST_W-1:0]       req_instrument_number,
   input  wire logic [SLOT_W-1:0]       req_arrange_slot,
   input  wire logic [ADDR_W-1:0]       req_sample_address,
   input  wire logic signed [SAMP_W-1:0] req_sample_value,
   input  wire logic [LEN_W-1:0]        req_sample_length,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [SUM_W-1:0]      rsp_left_sum,
   output logic signed [SUM_W-1:0]      rsp_right_sum,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   // memories
   logic [CELL_W-1:0] pattern_mem [CELL_TOTAL];
   logic [PAT_W-1:0]  arrange_mem [ARRANGE_DEPTH];
   logic [SAMP_W-1:0] sample_mem  [SAMPLE_TOTAL];
   logic [CELL_W-1:0] pat_rd_ff;
   logic [PAT_W-1:0]  arr_rd_ff;
   logic [SAMP_W-1:0] samp_rd_ff;

   // configuration and sequencing state
   logic [SPC_W-1:0]  spc_ff;
   logic [DIV_W-1:0]  div_ff;
   logic [ALEN_W-1:0] alen_ff;
   logic [LEN_W-1:0]  len_ff [INSTRUMENT_COUNT];
   logic [CNT_W-1:0]  cnt_ff  [CHANNELS];
   logic [NOTE_W-1:0] note_ff [CHANNELS];
   logic [INST_W-1:0] inst_ff [CHANNELS];
   logic [SPC_W-1:0]  tick_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [SLOT_W-1:0] arr_pos_ff;
   logic              playing_ff;
   state_type         state_ff, state_in;
   logic [CH_W-1:0]   ch_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic              rsp_valid_ff;
   logic signed [SUM_W-1:0] sum_ff;

   // per-channel work registers
   logic [CNT_W-1:0]  cnt_w_ff;
   logic [STEP_W-1:0] step_w_ff;
   logic [INST_W-1:0] inst_w_ff;
   logic [PART_W-1:0] p_lo_ff, p_hi_ff;
   logic [PROD_W-1:0] prod_ff;

   logic                accept, is_tick, last_ch, rsp_free;
   logic                retrig, in_range, len_ok, div_done;
   logic [INST_W-1:0]   cell_inst, inst_eff, inst_m1, wr_inst_m1;
   logic [NOTE_W-1:0]   cell_note, note_eff;
   logic [CNT_W-1:0]    cnt_eff;
   logic [POS_BITS-1:0] pos;
   logic [CELL_AW-1:0]  cell_addr;
   logic [SAMP_AW-1:0]  samp_addr;
   logic [SPC_W-1:0]    tick_next;
   logic [ALEN_W-1:0]   arr_next;
   logic                wr_inst_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_tick   = (req_mode == MODE_TICK);
   assign last_ch   = (ch_ff == CH_W'(CHANNELS - 1));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign cell_inst = pat_rd_ff[INST_W-1:0];
   assign cell_note = pat_rd_ff[CELL_W-1:INST_W];
   assign retrig    = (tick_ff == '0) && (cell_inst != '0);
   assign inst_eff  = retrig ? cell_inst : inst_ff[ch_ff];
   assign note_eff  = retrig ? cell_note : note_ff[ch_ff];
   assign cnt_eff   = retrig ? '0 : cnt_ff[ch_ff];
   assign inst_m1   = inst_w_ff - 1'b1;
   assign in_range  = prod_ff < {{(PROD_W - DIV_W - POS_BITS){1'b0}}, div_ff, {POS_BITS{1'b0}}};
   assign len_ok    = (inst_w_ff <= INST_W'(INSTRUMENT_COUNT))
                      && ({1'b0, pos} < len_ff[inst_m1]);
   assign cell_addr = {arr_rd_ff, row_ff, ch_ff};
   assign samp_addr = {inst_m1, pos};
   assign tick_next = tick_ff + 1'b1;
   assign arr_next  = {1'b0, arr_pos_ff} + 1'b1;
   assign wr_inst_ok = (req_instrument_number != '0)
                       && (req_instrument_number <= INST_W'(INSTRUMENT_COUNT));
   assign wr_inst_m1 = req_instrument_number - 1'b1;

   tsp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_RANGE && in_range),
      .num_hi   (prod_ff[DIV_W+POS_BITS-1:POS_BITS]),
      .num_lo   (prod_ff[POS_BITS-1:0]),
      .divisor  (div_ff),
      .done     (div_done),
      .quotient (pos)
   );

   // memory ports: write on load items, registered reads
   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_CELL) begin
         pattern_mem[{req_pattern_index, req_row, req_channel}] <=
            {req_note_number, req_instrument_number};
      end
      pat_rd_ff <= pattern_mem[cell_addr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_ARR) begin
         arrange_mem[req_arrange_slot] <= req_pattern_index;
      end
      arr_rd_ff <= arrange_mem[arr_pos_ff];
   end

   always_ff @(posedge clock) begin
      if (accept && req_mode == MODE_SAMPLE && wr_inst_ok) begin
         sample_mem[{wr_inst_m1, req_sample_address}] <= req_sample_value;
      end
      samp_rd_ff <= sample_mem[samp_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_tick) state_in = playing_ff ? ST_ARR : ST_FINISH;
         end
         ST_ARR:    state_in = ST_CELL;
         ST_CELL:   state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (inst_eff != '0) state_in = ST_MUL_LO;
            else                state_in = last_ch ? ST_TIMING : ST_CELL;
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_PROD;
         ST_PROD:   state_in = ST_RANGE;
         ST_RANGE: begin
            if (in_range) state_in = ST_DIVIDE;
            else          state_in = last_ch ? ST_TIMING : ST_CELL;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (len_ok) state_in = ST_SREAD;
               else        state_in = last_ch ? ST_TIMING : ST_CELL;
            end
         end
         ST_SREAD:  state_in = ST_ACCUM;
         ST_ACCUM:  state_in = last_ch ? ST_TIMING : ST_CELL;
         ST_TIMING: state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath work registers, no reset needed
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_DECIDE: begin
            cnt_w_ff  <= cnt_eff;
            step_w_ff <= NOTE_STEP[note_eff];
            inst_w_ff <= inst_eff;
         end
         ST_MUL_LO: p_lo_ff <= PART_W'(cnt_w_ff[HALF_W-1:0] * step_w_ff);
         ST_MUL_HI: p_hi_ff <= PART_W'(cnt_w_ff[CNT_W-1:HALF_W] * step_w_ff);
         ST_PROD:   prod_ff <= PROD_W'(p_lo_ff) + {p_hi_ff, {HALF_W{1'b0}}};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff       <= SPC_W'(5512);
         div_ff       <= DIV_W'(117867);
         alen_ff      <= ALEN_W'(1);
         for (int i = 0; i < INSTRUMENT_COUNT; i++) len_ff[i] <= LEN_W'(SAMPLE_DEPTH);
         for (int c = 0; c < CHANNELS; c++) begin
            cnt_ff[c]  <= '0;
            note_ff[c] <= '0;
            inst_ff[c] <= '0;
         end
         tick_ff      <= '0;
         row_ff       <= '0;
         arr_pos_ff   <= '0;
         playing_ff   <= 1'b0;
         ch_ff        <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SAMPLES_PER_CELL: spc_ff  <= csr_wdata[SPC_W-1:0];
               CSR_PITCH_DIVISOR:    div_ff  <= csr_wdata[DIV_W-1:0];
               CSR_ARRANGE_LENGTH:   alen_ff <= csr_wdata[ALEN_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_FINISH && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready)    rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_mode)
                     MODE_TICK: begin
                        ch_ff  <= '0;
                        acc_ff <= '0;
                     end
                     MODE_PLAY: begin
                        tick_ff    <= '0;
                        playing_ff <= 1'b1;
                     end
                     MODE_STOP: begin
                        tick_ff    <= '0;
                        playing_ff <= 1'b0;
                     end
                     MODE_LENGTH: begin
                        if (wr_inst_ok) len_ff[wr_inst_m1] <= req_sample_length;
                     end
                     default: ;
                  endcase
               end
            end
            ST_DECIDE: begin
               inst_ff[ch_ff] <= inst_eff;
               note_ff[ch_ff] <= note_eff;
               cnt_ff[ch_ff]  <= cnt_eff + 1'b1;
               if (inst_eff == '0 && !last_ch) ch_ff <= ch_ff + 1'b1;
            end
            ST_RANGE: begin
               if (!in_range) begin
                  // silence: counter cleared then advanced
                  inst_ff[ch_ff] <= '0;
                  cnt_ff[ch_ff]  <= CNT_W'(1);
                  if (!last_ch) ch_ff <= ch_ff + 1'b1;
               end
            end
            ST_DIVIDE: begin
               if (div_done && !len_ok) begin
                  inst_ff[ch_ff] <= '0;
                  cnt_ff[ch_ff]  <= CNT_W'(1);
                  if (!last_ch) ch_ff <= ch_ff + 1'b1;
               end
            end
            ST_ACCUM: begin
               acc_ff <= acc_ff + ACC_W'($signed(samp_rd_ff));
               if (!last_ch) ch_ff <= ch_ff + 1'b1;
            end
            ST_TIMING: begin
               if (tick_next == spc_ff) begin
                  tick_ff <= '0;
                  // the row wraps to zero at the end of the pattern
                  row_ff  <= row_ff + 1'b1;
                  if (row_ff == ROW_W'(ROWS_PER_PATTERN - 1)) begin
                     if (arr_next >= alen_ff || arr_next >= ALEN_W'(ARRANGE_DEPTH))
                        arr_pos_ff <= '0;
                     else
                        arr_pos_ff <= arr_next[SLOT_W-1:0];
                  end
               end else begin
                  tick_ff <= tick_next;
               end
            end
            default: ;
         endcase
      end
   end

   // saturate the channel sum onto the result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && rsp_free) begin
         if (acc_ff > SUM_MAX)      sum_ff <= SUM_MAX[SUM_W-1:0];
         else if (acc_ff < SUM_MIN) sum_ff <= SUM_MIN[SUM_W-1:0];
         else                       sum_ff <= acc_ff[SUM_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_sum  = sum_ff;
   assign rsp_right_sum = sum_ff;

endmodule
`default_nettype wire

// ----- src/tsp_checker.sv -----
// tsp_checker: port-level assertions for tracker_sample_player, bound to the top.
// Uses tsp_pkg for widths and mode codes.
`default_nettype none
module tsp_checker import tsp_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic [2:0]               req_mode,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [SUM_W-1:0]  rsp_left_sum,
   input wire logic signed [SUM_W-1:0]  rsp_right_sum
);

   // a held item keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_sum))
      else $error("result item changed while stalled");

   a_lr_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_sum == rsp_right_sum)
      else $error("left and right sums differ");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item after reset");

   // load items produce no result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode != MODE_TICK && !rsp_valid |=> !rsp_valid)
      else $error("result item from a load item");

endmodule

bind tracker_sample_player tsp_checker u_tsp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_mode      (req_mode),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_left_sum  (rsp_left_sum),
   .rsp_right_sum (rsp_right_sum)
);
`default_nettype wire

// ----- tb/tsp_checker.sv -----
// tsp_scoreboard: watches the request, result and register ports of the tracker sample
// player, predicts each tick's mix and compares it. Depends on tsp_pkg.
module tsp_scoreboard import tsp_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [2:0]               req_mode,
   input  wire logic [PAT_W-1:0]         req_pattern_index,
   input  wire logic [CH_W-1:0]          req_channel,
   input  wire logic [ROW_W-1:0]         req_row,
   input  wire logic [NOTE_W-1:0]        req_note_number,
   input  wire logic [INST_W-1:0]        req_instrument_number,
   input  wire logic [SLOT_W-1:0]        req_arrange_slot,
   input  wire logic [ADDR_W-1:0]        req_sample_address,
   input  wire logic signed [SAMP_W-1:0] req_sample_value,
   input  wire logic [LEN_W-1:0]         req_sample_length,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic signed [SUM_W-1:0]  rsp_left_sum,
   input  wire logic signed [SUM_W-1:0]  rsp_right_sum,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [SPC_W-1:0]  ticks_per_row;
   logic [DIV_W-1:0]  divisor;
   logic [ALEN_W-1:0] song_length;

   logic [CELL_W-1:0] cells [CELL_TOTAL];
   logic [PAT_W-1:0]  song [ARRANGE_DEPTH];
   logic [SAMP_W-1:0] wave [SAMPLE_TOTAL];
   logic [LEN_W-1:0]  wave_len [INSTRUMENT_COUNT];
   logic [STEP_W-1:0] steps [128];
   logic [CNT_W-1:0]  voice_cnt [CHANNELS];
   logic [NOTE_W-1:0] voice_note [CHANNELS];
   logic [INST_W-1:0] voice_inst [CHANNELS];
   logic [SPC_W-1:0]  tick_pos;
   int                row_pos;
   int                song_pos;
   bit                playing;

   logic signed [SUM_W-1:0] mix_queue [$];

   initial begin
      int unsigned base [12];
      base = '{8572947, 9082720, 9622807, 10195009, 10801236, 11443511,
               12123977, 12844906, 13608704, 14417920, 15275254, 16183568};
      for (int n = 0; n < 128; n++)
         steps[n] = (n < 12) ? '0 : STEP_W'(base[n % 12] >> (10 - n / 12));
      ticks_per_row = 16'd5512;
      divisor       = 24'd117867;
      song_length   = 7'd1;
      foreach (wave_len[i]) wave_len[i] = LEN_W'(SAMPLE_DEPTH);
      foreach (voice_cnt[c]) begin
         voice_cnt[c]  = '0;
         voice_note[c] = '0;
         voice_inst[c] = '0;
      end
      tick_pos   = '0;
      row_pos    = 0;
      song_pos   = 0;
      playing    = 0;
      fail_count = 0;
   end

   assign pending = mix_queue.size();

   // advance the player by one audio tick and give the expected mix
   task automatic mix_tick(output logic signed [SUM_W-1:0] mix);
      int                sum;
      int                pat;
      int                ci;
      logic [CELL_W-1:0] row_cell;
      longint unsigned   prod;
      longint unsigned   pos;
      sum = 0;
      pat = song[song_pos];
      if (!playing) begin
         mix = '0;
         return;
      end
      for (int c = 0; c < CHANNELS; c++) begin
         row_cell = cells[(pat * ROWS_PER_PATTERN + row_pos) * CHANNELS + c];
         if (tick_pos == 0 && row_cell[INST_W-1:0] != 0) begin
            voice_cnt[c]  = '0;
            voice_note[c] = row_cell[CELL_W-1:INST_W];
            voice_inst[c] = row_cell[INST_W-1:0];
         end
         if (voice_inst[c] != 0) begin
            ci   = voice_inst[c] - 1;
            prod = longint'(voice_cnt[c]) * longint'(steps[voice_note[c]]);
            pos  = (divisor != 0) ? prod / longint'(divisor) : '1;
            if (ci < INSTRUMENT_COUNT && pos < wave_len[ci] && pos < SAMPLE_DEPTH) begin
               sum += int'($signed(wave[ci * SAMPLE_DEPTH + int'(pos)]));
            end else begin
               voice_inst[c] = '0;
               voice_cnt[c]  = '0;
            end
         end
         voice_cnt[c] = voice_cnt[c] + 1;
      end
      tick_pos = tick_pos + 1;
      if (tick_pos == ticks_per_row) begin
         tick_pos = '0;
         row_pos++;
         if (row_pos >= ROWS_PER_PATTERN) begin
            row_pos = 0;
            song_pos++;
            if (song_pos >= song_length || song_pos >= ARRANGE_DEPTH) song_pos = 0;
         end
      end
      if (sum > 131071) sum = 131071;
      if (sum < -131072) sum = -131072;
      mix = SUM_W'(sum);
   endtask

   always @(posedge clock) begin
      logic signed [SUM_W-1:0] mix;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_SAMPLES_PER_CELL: ticks_per_row = csr_wdata[SPC_W-1:0];
               CSR_PITCH_DIVISOR:    divisor       = csr_wdata[DIV_W-1:0];
               CSR_ARRANGE_LENGTH:   song_length   = csr_wdata[ALEN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (mix_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result item: left %0d right %0d",
                           rsp_left_sum, rsp_right_sum);
            end else begin
               mix = mix_queue.pop_front();
               if (rsp_left_sum !== mix || rsp_right_sum !== mix) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mix mismatch: expected %0d, got left %0d right %0d",
                              mix, rsp_left_sum, rsp_right_sum);
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req_mode)
               MODE_TICK: begin
                  mix_tick(mix);
                  mix_queue.push_back(mix);
               end
               MODE_PLAY: begin
                  tick_pos = '0;
                  playing  = 1;
               end
               MODE_STOP: begin
                  tick_pos = '0;
                  playing  = 0;
               end
               MODE_CELL:
                  cells[(int'(req_pattern_index) * ROWS_PER_PATTERN + int'(req_row)) * CHANNELS
                        + int'(req_channel)] = {req_note_number, req_instrument_number};
               MODE_ARR: song[req_arrange_slot] = req_pattern_index;
               MODE_SAMPLE:
                  if (req_instrument_number >= 1 && req_instrument_number <= INSTRUMENT_COUNT)
                     wave[(int'(req_instrument_number) - 1) * SAMPLE_DEPTH
                          + int'(req_sample_address)] = req_sample_value;
               MODE_LENGTH:
                  if (req_instrument_number >= 1 && req_instrument_number <= INSTRUMENT_COUNT)
                     wave_len[req_instrument_number - 1] = req_sample_length;
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- tb/tb_top.sv -----
// tb_top: clock, reset, request and register stimulus and the verdict for the tracker
// sample player. Depends on tsp_pkg, tracker_sample_player and tsp_scoreboard.
module tb_top;
   import tsp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int HOLD_CYCLES    = 2000;
   localparam int LOADED         = 16;   // sample words written per instrument
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 98;
   localparam logic [2:0] MODE_IGNORED = 3'd7;

   typedef struct {
      logic [2:0]        mode;
      logic [PAT_W-1:0]  pat;
      logic [CH_W-1:0]   ch;
      logic [ROW_W-1:0]  row;
      logic [NOTE_W-1:0] note;
      logic [INST_W-1:0] inst;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] addr;
      logic [SAMP_W-1:0] sval;
      logic [LEN_W-1:0]  slen;
   } command_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_mode = '0;
   logic [PAT_W-1:0] req_pattern_index = '0;
   logic [CH_W-1:0] req_channel = '0;
   logic [ROW_W-1:0] req_row = '0;
   logic [NOTE_W-1:0] req_note_number = '0;
   logic [INST_W-1:0] req_instrument_number = '0;
   logic [SLOT_W-1:0] req_arrange_slot = '0;
   logic [ADDR_W-1:0] req_sample_address = '0;
   logic signed [SAMP_W-1:0] req_sample_value = '0;
   logic [LEN_W-1:0] req_sample_length = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SUM_W-1:0] rsp_left_sum, rsp_right_sum;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count, pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet = 0;
   int hold_left = 0;
   bit hold_go = 0;
   bit hold_done = 0;

   always #5 clock = ~clock;

   tracker_sample_player dut (.*);

   tsp_scoreboard u_scoreboard (.*);

   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done <= 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic command_type noise(logic [2:0] mode);
      command_type c;
      c.mode = mode;
      c.pat  = PAT_W'($urandom);
      c.ch   = CH_W'($urandom);
      c.row  = ROW_W'($urandom);
      c.note = NOTE_W'($urandom);
      c.inst = INST_W'($urandom);
      c.slot = SLOT_W'($urandom);
      c.addr = ADDR_W'($urandom);
      c.sval = SAMP_W'($urandom);
      c.slen = LEN_W'($urandom);
      return c;
   endfunction

   // offer one item after a random gap and hold it until accepted
   task automatic send(command_type c);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_mode              <= c.mode;
      req_pattern_index     <= c.pat;
      req_channel           <= c.ch;
      req_row               <= c.row;
      req_note_number       <= c.note;
      req_instrument_number <= c.inst;
      req_arrange_slot      <= c.slot;
      req_sample_address    <= c.addr;
      req_sample_value      <= c.sval;
      req_sample_length     <= c.slen;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // drain every expected mix, then let the block finish a silent item
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(int spc, int divisor, int song_len);
      csr_we    <= 1'b1;
      csr_index <= CSR_SAMPLES_PER_CELL;
      csr_wdata <= CSR_DATA_W'(spc);
      @(posedge clock);
      csr_index <= CSR_PITCH_DIVISOR;
      csr_wdata <= CSR_DATA_W'(divisor);
      @(posedge clock);
      csr_index <= CSR_ARRANGE_LENGTH;
      csr_wdata <= CSR_DATA_W'(song_len);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic send_length(int inst, int len);
      command_type c;
      c      = noise(MODE_LENGTH);
      c.inst = INST_W'(inst);
      c.slen = LEN_W'(len);
      send(c);
   endtask

   // only patterns 0 and 1 are fully written, so the song names only those
   task automatic random_item();
      command_type c;
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) c = noise(MODE_TICK);
      else if (pick < 60) c = noise(MODE_PLAY);
      else if (pick < 63) c = noise(MODE_STOP);
      else if (pick < 78) c = noise(MODE_CELL);
      else if (pick < 83) begin
         c     = noise(MODE_ARR);
         c.pat = PAT_W'($urandom_range(1));
      end else if (pick < 90) begin
         c = noise(MODE_SAMPLE);
         if ($urandom_range(1)) c.addr = ADDR_W'($urandom_range(LOADED - 1));
      end else if (pick < 95) begin
         c      = noise(MODE_LENGTH);
         c.slen = LEN_W'($urandom_range(LOADED));
         if ($urandom_range(9) == 0) begin
            send_length(c.inst, $urandom);
         end
      end else c = noise(MODE_IGNORED);
      send(c);
   endtask

   initial begin
      command_type c;
      int spc, divisor, song_len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // load songs, samples and lengths
      for (int i = 1; i <= INSTRUMENT_COUNT; i++) begin
         send_length(i, LOADED);
         for (int a = 0; a < LOADED; a++) begin
            c      = noise(MODE_SAMPLE);
            c.inst = INST_W'(i);
            c.addr = ADDR_W'(a);
            if (i == 1) c.sval = 16'h8000;
            else if (i == 2) c.sval = 16'h7FFF;
            send(c);
         end
      end
      for (int p = 0; p < 2; p++)
         for (int r = 0; r < ROWS_PER_PATTERN; r++)
            for (int ch = 0; ch < CHANNELS; ch++) begin
               c     = noise(MODE_CELL);
               c.pat = PAT_W'(p);
               c.row = ROW_W'(r);
               c.ch  = CH_W'(ch);
               if (p == 0 && r == 0) begin
                  c.inst = 4'd1;
                  c.note = 7'd60;
               end
               send(c);
            end
      for (int s = 0; s < ARRANGE_DEPTH; s++) begin
         c      = noise(MODE_ARR);
         c.slot = SLOT_W'(s);
         c.pat  = (s == 0) ? '0 : PAT_W'($urandom_range(1));
         send(c);
      end

      // directed: stopped tick, full negative mix, edges of the fields
      send(noise(MODE_TICK));
      send(noise(MODE_PLAY));
      repeat (3) send(noise(MODE_TICK));
      send(noise(MODE_IGNORED));
      c      = noise(MODE_SAMPLE);
      c.inst = 4'd0;
      send(c);
      send_length(0, 4);
      c      = noise(MODE_SAMPLE);
      c.inst = 4'd15;
      c.addr = 13'h1FFF;
      c.sval = 16'h7FFF;
      send(c);
      send_length(15, SAMPLE_DEPTH);
      send_length(15, 14'h1FFF);
      send_length(15, LOADED);
      c      = noise(MODE_CELL);
      c.pat  = 4'd15;
      c.row  = 6'd63;
      c.ch   = 2'd3;
      c.note = 7'd127;
      c.inst = 4'd15;
      send(c);
      c.note = 7'd0;
      c.inst = 4'd0;
      send(c);
      repeat (2) send(noise(MODE_TICK));
      send(noise(MODE_STOP));
      send(noise(MODE_TICK));
      send(noise(MODE_PLAY));
      repeat (3) send(noise(MODE_TICK));

      for (int p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin spc = 1;     divisor = 1;        song_len = 1;  end
            1: begin spc = 65535; divisor = 16777215; song_len = 64; end
            2: begin spc = 2;     divisor = 117867;   song_len = 64; end
            3: begin spc = 3;     divisor = 600000;   song_len = 7;  end
            default: begin
               spc      = $urandom_range(8, 1);
               divisor  = $urandom_range(2000000, 20000);
               song_len = $urandom_range(64, 1);
            end
         endcase
         write_regs(spc, divisor, song_len);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 83; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 83; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         send(noise(MODE_PLAY));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == 20) hold_go <= 1;
            random_item();
         end
      end

      idle_pct  = 0;
      stall_pct = 0;
      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
